// File: design/rmdr_pkg.sv
// ----------------------------------------------------------------------------
// rmdr_pkg: shared constants for the running mean / deviation block
// Fixed-point formats, saturation limits and divider sizing.
// ----------------------------------------------------------------------------
package rmdr_pkg;

  // Fixed-point format of samples and reliability
  localparam int FRAC_BITS = 16;

  // Sample count saturates here
  localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;

  // 100.0 in the reliability format
  localparam logic [22:0] HUNDRED_FX = 23'(100 << FRAC_BITS);

  // Shared divider: dividend register width and iteration counter width
  localparam int DIV_W = 56;
  localparam int CNT_W = $clog2(DIV_W);

  // Dividend widths of the sum divisions and of the reliability-sum division
  localparam int SUM_W = 48;
  localparam int RSUM_W = 40;

  // Division being run by the shared divider
  localparam logic [2:0] OP_OLD   = 3'd0;
  localparam logic [2:0] OP_MEAN  = 3'd1;
  localparam logic [2:0] OP_MLD   = 3'd2;
  localparam logic [2:0] OP_RATIO = 3'd3;
  localparam logic [2:0] OP_REL   = 3'd4;

endpackage

// File: design/running_mean_deviation_reliability.sv
// ----------------------------------------------------------------------------
// running_mean_deviation_reliability
// Running mean, mean absolute deviation and reliability of a Q15.16 stream,
// computed with one shared radix-2 restoring divider under a sequencer.
// ----------------------------------------------------------------------------
// Sequence: old mean, new mean and mean deviation divisions, then a ratio division when
//   the shift is below the deviation, then the reliability average; first and overflowed items skip all of them.
// Flow: one item at a time; no new item is taken until its result is done. The shared
//   divider (one quotient bit per cycle; 48-, 48-, 48-, 56- and 40-bit quotients) sets the pace. Ready
//   returns with result valid, once the output register has taken the result.
// Reset (rst, synchronous): all sums, the count and held outputs clear.
module running_mean_deviation_reliability (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] mean,
  output logic        [31:0] abs_deviation,
  output logic        [22:0] reliability,
  output logic        [15:0] count,
  output logic               overflow
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_POST  = 4'd2;
  localparam logic [3:0] S_AD    = 4'd3;
  localparam logic [3:0] S_DSUM  = 4'd4;
  localparam logic [3:0] S_SHIFT = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_RSUM  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam int PAD_SUM  = rmdr_pkg::DIV_W - rmdr_pkg::SUM_W;
  localparam int PAD_RSUM = rmdr_pkg::DIV_W - rmdr_pkg::RSUM_W;

  // Control
  logic [3:0]                 state;
  logic [2:0]                 op;
  logic [rmdr_pkg::CNT_W-1:0] cnt;
  logic                       ovf_r;

  // Accumulated state
  logic [47:0] value_sum;
  logic [47:0] deviation_sum;
  logic [39:0] reliability_sum;
  logic [15:0] sample_total;
  logic [31:0] mean_reg;
  logic [31:0] deviation_reg;
  logic [22:0] reliability_reg;

  // Per-item working registers
  logic [31:0] sample_r;
  logic [48:0] sum2;
  logic        old_neg;
  logic [31:0] old_mean;
  logic [31:0] mean_v;
  logic [32:0] ad;
  logic [32:0] shift;
  logic [31:0] mld;
  logic [22:0] add_r;

  // Shared divider
  logic [rmdr_pkg::DIV_W-1:0] q;
  logic [31:0]                rem;
  logic [31:0]                den;

  // Combinational helpers
  logic [32:0] rem_sh;
  logic        rem_ge;
  logic [32:0] rem_sub;
  logic [48:0] sum2_c;
  logic [47:0] vs_mag;
  logic [48:0] sum2_neg;
  logic [32:0] dev_diff;
  logic [32:0] shift_diff;
  logic [48:0] dsum_ext;
  logic [47:0] dsum_new;
  logic [40:0] rsum_ext;
  logic [39:0] rsum_new;
  logic [47:0] vs_sat;
  logic [15:0] n_inc;

  // Signed quotient from magnitude, clamped to 32 bits
  function automatic logic [31:0] clamp_q(input logic [rmdr_pkg::DIV_W-1:0] mag,
                                          input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (mag > rmdr_pkg::DIV_W'(33'h0_8000_0000)) r = 32'h8000_0000;
      else r = ~mag[31:0] + 32'd1;
    end else begin
      if (mag > rmdr_pkg::DIV_W'(33'h0_7FFF_FFFF)) r = 32'h7FFF_FFFF;
      else r = mag[31:0];
    end
    return r;
  endfunction

  // Divider step: one quotient bit per cycle
  assign rem_sh  = {rem, q[rmdr_pkg::DIV_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  // Accept-time operand prep
  assign sum2_c   = {value_sum[47], value_sum} + {{17{sample[31]}}, sample};
  assign vs_mag   = value_sum[47] ? (~value_sum + 48'd1) : value_sum;
  assign sum2_neg = ~sum2 + 49'd1;

  // Deviation and mean shift differences
  assign dev_diff   = {mean_v[31], mean_v} - {sample_r[31], sample_r};
  assign shift_diff = {old_mean[31], old_mean} - {mean_v[31], mean_v};

  // Saturating accumulators
  assign dsum_ext = {1'b0, deviation_sum} + {16'd0, ad};
  assign dsum_new = dsum_ext[48] ? 48'hFFFF_FFFF_FFFF : dsum_ext[47:0];
  assign rsum_ext = {1'b0, reliability_sum} + {18'd0, add_r};
  assign rsum_new = rsum_ext[40] ? 40'hFF_FFFF_FFFF : rsum_ext[39:0];
  assign vs_sat   = (sum2[48] != sum2[47])
                  ? (sum2[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF)
                  : sum2[47:0];
  assign n_inc    = sample_total + 16'd1;

  assign in_ready = (state == S_IDLE);

  // Sequencer, datapath and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      op              <= rmdr_pkg::OP_OLD;
      cnt             <= '0;
      ovf_r           <= 1'b0;
      value_sum       <= '0;
      deviation_sum   <= '0;
      reliability_sum <= '0;
      sample_total    <= '0;
      mean_reg        <= '0;
      deviation_reg   <= '0;
      reliability_reg <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_r <= sample;
            sum2     <= sum2_c;
            old_neg  <= value_sum[47];
            if (sample_total == 16'd0) begin
              // first item seeds the sum only
              mean_reg        <= '0;
              deviation_reg   <= '0;
              reliability_reg <= '0;
              value_sum       <= {{16{sample[31]}}, sample};
              deviation_sum   <= '0;
              reliability_sum <= '0;
              sample_total    <= 16'd1;
              ovf_r           <= 1'b0;
              state           <= S_DONE;
            end else if (sample_total >= rmdr_pkg::COUNT_LIMIT) begin
              ovf_r <= 1'b1;
              state <= S_DONE;
            end else begin
              // old mean: |value_sum| / n
              ovf_r <= 1'b0;
              q     <= {vs_mag, PAD_SUM'(0)};
              rem   <= '0;
              den   <= {16'd0, sample_total};
              cnt   <= rmdr_pkg::CNT_W'(rmdr_pkg::SUM_W - 1);
              op    <= rmdr_pkg::OP_OLD;
              state <= S_DIV;
            end
          end
        end

        S_DIV: begin
          rem <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
          q   <= {q[rmdr_pkg::DIV_W-2:0], rem_ge};
          cnt <= cnt - rmdr_pkg::CNT_W'(1);
          if (cnt == '0) state <= S_POST;
        end

        S_POST: begin
          unique case (op)
            rmdr_pkg::OP_OLD: begin
              // new mean: |value_sum + sample| / (n + 1)
              old_mean <= clamp_q(q, old_neg);
              q        <= {(sum2[48] ? sum2_neg[47:0] : sum2[47:0]), PAD_SUM'(0)};
              rem      <= '0;
              den      <= {16'd0, n_inc};
              cnt      <= rmdr_pkg::CNT_W'(rmdr_pkg::SUM_W - 1);
              op       <= rmdr_pkg::OP_MEAN;
              state    <= S_DIV;
            end
            rmdr_pkg::OP_MEAN: begin
              mean_v <= clamp_q(q, sum2[48]);
              state  <= S_AD;
            end
            rmdr_pkg::OP_MLD: begin
              mld   <= (q > rmdr_pkg::DIV_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : q[31:0];
              state <= S_SHIFT;
            end
            rmdr_pkg::OP_RATIO: begin
              add_r <= rmdr_pkg::HUNDRED_FX - q[22:0];
              state <= S_RSUM;
            end
            rmdr_pkg::OP_REL: begin
              reliability_reg <= (q > rmdr_pkg::DIV_W'(23'h7F_FFFF)) ? 23'h7F_FFFF
                                                                     : q[22:0];
              mean_reg        <= mean_v;
              deviation_reg   <= mld;
              state           <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end

        S_AD: begin
          ad    <= dev_diff[32] ? (~dev_diff + 33'd1) : dev_diff;
          state <= S_DSUM;
        end

        S_DSUM: begin
          // mean absolute deviation: deviation_sum / n
          deviation_sum <= dsum_new;
          q             <= {dsum_new, PAD_SUM'(0)};
          rem           <= '0;
          den           <= {16'd0, sample_total};
          cnt           <= rmdr_pkg::CNT_W'(rmdr_pkg::SUM_W - 1);
          op            <= rmdr_pkg::OP_MLD;
          state         <= S_DIV;
        end

        S_SHIFT: begin
          if (mld == 32'd0) begin
            add_r <= rmdr_pkg::HUNDRED_FX;
            state <= S_RSUM;
          end else begin
            shift <= shift_diff[32] ? (~shift_diff + 33'd1) : shift_diff;
            state <= S_MUL;
          end
        end

        S_MUL: begin
          if (shift < {1'b0, mld}) begin
            // ratio: shift * 100 / deviation
            q     <= rmdr_pkg::DIV_W'(shift[31:0] * rmdr_pkg::HUNDRED_FX);
            rem   <= '0;
            den   <= mld;
            cnt   <= rmdr_pkg::CNT_W'(rmdr_pkg::DIV_W - 1);
            op    <= rmdr_pkg::OP_RATIO;
            state <= S_DIV;
          end else begin
            add_r <= '0;
            state <= S_RSUM;
          end
        end

        S_RSUM: begin
          // commit sums, then average reliability over n + 1
          reliability_sum <= rsum_new;
          value_sum       <= vs_sat;
          sample_total    <= n_inc;
          q               <= {rsum_new, PAD_RSUM'(0)};
          rem             <= '0;
          den             <= {16'd0, n_inc};
          cnt             <= rmdr_pkg::CNT_W'(rmdr_pkg::RSUM_W - 1);
          op              <= rmdr_pkg::OP_REL;
          state           <= S_DIV;
        end

        S_DONE: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: loaded when the result is done and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      mean          <= mean_reg;
      abs_deviation <= deviation_reg;
      reliability   <= reliability_reg;
      count         <= sample_total;
      overflow      <= ovf_r;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block still ready after accepting an item");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < den)
    else $error("divider remainder not below divisor");

  a_ovf_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> count == rmdr_pkg::COUNT_LIMIT)
    else $error("overflow flagged below count limit");

  a_rel_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reliability <= rmdr_pkg::HUNDRED_FX)
    else $error("reliability above 100");

endmodule

// File: dv/running_mean_deviation_reliability_test.sv
// ----------------------------------------------------------------------------
// running_mean_deviation_reliability_test
// Self-checking bench for the running mean / deviation / reliability block.
// A clocked driver feeds samples from a backlog queue. A clocked monitor
// compares every result against a bit-exact predictor that is stepped at
// each accepted item. Sender and receiver idle at random in the first two
// of three phases, and the receiver holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module running_mean_deviation_reliability_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint          s64_t;
  typedef longint unsigned u64_t;

  // One result item, laid out as the output ports
  typedef struct packed {
    logic signed [31:0] mean;
    logic        [31:0] abs_deviation;
    logic        [22:0] reliability;
    logic        [15:0] count;
    logic               overflow;
  } stats_t;

  localparam int DIRECTED_ITEMS = 20;
  localparam int RANDOM_ITEMS   = 1930;
  localparam int PHASE1_START   = DIRECTED_ITEMS + RANDOM_ITEMS / 3;
  localparam int PHASE2_START   = DIRECTED_ITEMS + (2 * RANDOM_ITEMS) / 3;
  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = 300;

  // DUT ports
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] mean;
  logic        [31:0] abs_deviation;
  logic        [22:0] reliability;
  logic        [15:0] count;
  logic               overflow;

  // Bench bookkeeping
  logic signed [31:0] sample_backlog[$];
  stats_t             stats_due[$];
  stats_t             want;
  int                 total_items = 0;
  int                 samples_issued = 0;
  int                 samples_taken = 0;
  int                 stats_seen = 0;
  int                 mismatches = 0;
  logic               hold_off = 1'b0;

  // Predictor state: running sums and held outputs
  logic signed [47:0] sum_acc = '0;
  logic        [47:0] dev_acc = '0;
  logic        [39:0] rel_acc = '0;
  logic        [15:0] n_acc = '0;
  logic        [31:0] mean_q = '0;
  logic        [31:0] dev_q = '0;
  logic        [22:0] rel_q = '0;

  running_mean_deviation_reliability DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mean         (mean),
    .abs_deviation(abs_deviation),
    .reliability  (reliability),
    .count        (count),
    .overflow     (overflow)
  );

  // Saturate to signed 32 bits
  function automatic s64_t sat32(s64_t v);
    if (v > s64_t'(32'sh7FFF_FFFF)) return s64_t'(32'sh7FFF_FFFF);
    if (v < -s64_t'(64'h8000_0000)) return -s64_t'(64'h8000_0000);
    return v;
  endfunction

  // Step the running statistics by one sample and return the result item
  function automatic stats_t advance_stats(logic signed [31:0] s_in);
    stats_t r;
    s64_t   s, vs, n, old_m, new_m, d, sh, nsum;
    u64_t   ad, dev_l, mld, shift, rel_l, q, hundred;
    logic   ign;
    hundred = u64_t'(rmdr_pkg::HUNDRED_FX);
    s = s64_t'(s_in);
    ign = 1'b0;
    if (n_acc == 16'd0) begin
      // first sample only seeds the sum
      mean_q  = '0;
      dev_q   = '0;
      rel_q   = '0;
      sum_acc = s[47:0];
      dev_acc = '0;
      rel_acc = '0;
      n_acc   = 16'd1;
    end else if (n_acc >= rmdr_pkg::COUNT_LIMIT) begin
      // saturated count: sample dropped, held values repeat
      ign = 1'b1;
    end else begin
      n     = s64_t'(n_acc);
      vs    = s64_t'(sum_acc);
      old_m = sat32(vs / n);
      new_m = sat32((vs + s) / (n + 1));
      d     = new_m - s;
      ad    = (d < 0) ? u64_t'(-d) : u64_t'(d);

      dev_l = u64_t'(dev_acc) + ad;
      if (dev_l > 64'hFFFF_FFFF_FFFF) dev_l = 64'hFFFF_FFFF_FFFF;
      dev_acc = dev_l[47:0];
      mld = dev_l / u64_t'(n);
      if (mld > 64'hFFFF_FFFF) mld = 64'hFFFF_FFFF;

      // reliability score of this sample
      rel_l = u64_t'(rel_acc);
      if (mld == 0) begin
        rel_l = rel_l + hundred;
      end else begin
        sh    = old_m - new_m;
        shift = (sh < 0) ? u64_t'(-sh) : u64_t'(sh);
        if (shift < mld) rel_l = rel_l + hundred - (shift * hundred) / mld;
      end
      if (rel_l > 64'hFF_FFFF_FFFF) rel_l = 64'hFF_FFFF_FFFF;
      rel_acc = rel_l[39:0];

      nsum = vs + s;
      if (nsum > s64_t'(64'h7FFF_FFFF_FFFF)) nsum = s64_t'(64'h7FFF_FFFF_FFFF);
      if (nsum < -s64_t'(64'h8000_0000_0000)) nsum = -s64_t'(64'h8000_0000_0000);
      sum_acc = nsum[47:0];
      n_acc   = n_acc + 16'd1;

      mean_q = new_m[31:0];
      dev_q  = mld[31:0];
      q      = rel_l / u64_t'(n + 1);
      rel_q  = (q > 64'h7F_FFFF) ? 23'h7F_FFFF : q[22:0];
    end
    r.mean          = mean_q;
    r.abs_deviation = dev_q;
    r.reliability   = rel_q;
    r.count         = n_acc;
    r.overflow      = ign;
    return r;
  endfunction

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Driver: offers backlog items, predicts each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        stats_due.push_back(advance_stats(sample));
        samples_taken <= samples_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (sample_backlog.size() != 0 &&
            $urandom_range(99) >= ((samples_issued < PHASE1_START) ? 30 :
                                   (samples_issued < PHASE2_START) ? 48 : 0)) begin
          in_valid <= 1'b1;
          sample   <= sample_backlog.pop_front();
          samples_issued <= samples_issued + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        stats_seen <= stats_seen + 1;
        if (stats_due.size() == 0) begin
          $error("result item with no sample pending");
          mismatches++;
        end else begin
          want = stats_due.pop_front();
          if (mean !== want.mean) begin
            $error("mean: expected %0d, actual %0d", $signed(want.mean), $signed(mean));
            mismatches++;
          end
          if (abs_deviation !== want.abs_deviation) begin
            $error("abs_deviation: expected %0d, actual %0d",
                   want.abs_deviation, abs_deviation);
            mismatches++;
          end
          if (reliability !== want.reliability) begin
            $error("reliability: expected %0d, actual %0d", want.reliability, reliability);
            mismatches++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, count);
            mismatches++;
          end
          if (overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, overflow);
            mismatches++;
          end
        end
      end
      out_ready <= !hold_off &&
                   ($urandom_range(99) >= ((stats_seen < PHASE1_START) ? 48 :
                                           (stats_seen < PHASE2_START) ? 30 : 0));
    end
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    while (stats_seen < PHASE2_START + 50) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Stimulus, reset and end of run
  initial begin
    logic signed [31:0] center;
    logic signed [31:0] prev;
    logic signed [31:0] pick;
    int                 kind;

    // Directed: zero-deviation run on the seed, then the field extremes
    sample_backlog.push_back(32'sh8000_0000);
    sample_backlog.push_back(32'sh8000_0000);
    sample_backlog.push_back(32'sh8000_0000);
    sample_backlog.push_back(32'sh8000_0000);
    sample_backlog.push_back(32'sh7FFF_FFFF);
    sample_backlog.push_back(32'sh7FFF_FFFF);
    sample_backlog.push_back(32'sh8000_0000);
    sample_backlog.push_back(32'sh0000_0000);
    sample_backlog.push_back(32'shFFFF_FFFF);
    sample_backlog.push_back(32'sh0000_0001);
    sample_backlog.push_back(32'sh0001_0000);
    sample_backlog.push_back(-32'sh0001_0000);
    sample_backlog.push_back(32'sh7FFF_0000);
    sample_backlog.push_back(32'sh8000_0001);
    sample_backlog.push_back(32'sh0000_0000);
    sample_backlog.push_back(32'sh0000_0000);
    sample_backlog.push_back(32'sh0000_0000);
    sample_backlog.push_back(32'sh5555_5555);
    sample_backlog.push_back(32'shAAAA_AAAA);
    sample_backlog.push_back(32'sh0000_8000);

    // Random: mostly a noisy drifting signal, with repeats, jumps and extremes
    center = 32'sh0000_0000;
    prev   = 32'sh0000_8000;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(99);
      if ($urandom_range(99) < 5) center = $signed($urandom) >>> $urandom_range(8, 1);
      if (kind < 45) begin
        pick = center + ($signed($urandom) >>> $urandom_range(31, 11));
      end else if (kind < 65) begin
        pick = $urandom;
      end else if (kind < 80) begin
        pick = prev;
      end else if (kind < 90) begin
        case ($urandom_range(3))
          0: pick = 32'sh7FFF_FFFF;
          1: pick = 32'sh8000_0000;
          2: pick = 32'sh0000_0000;
          default: pick = 32'shFFFF_FFFF;
        endcase
      end else begin
        pick = -center + ($signed($urandom) >>> $urandom_range(4, 2));
      end
      sample_backlog.push_back(pick);
      prev = pick;
    end
    total_items = sample_backlog.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (samples_taken < total_items) @(posedge clk);
    while (stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && stats_due.size() == 0) begin
      $display("running_mean_deviation_reliability_test: PASS");
    end else begin
      $display("running_mean_deviation_reliability_test: FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(64'd30_000_000);
    $display("running_mean_deviation_reliability_test: FAIL");
    $finish;
  end

endmodule
